// ----- hw/rtl/mfqs_pkg.sv -----
package mfqs_pkg;

  localparam int ID_W      = 6;
  localparam int NUM_PROCS = 1 << ID_W;
  localparam int CNT_W     = ID_W + 1;

  typedef enum logic [2:0] {
    FN_ADMIT    = 3'd0,
    FN_YIELD    = 3'd1,
    FN_WAKE     = 3'd2,
    FN_DISPATCH = 3'd3,
    FN_BOOST    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BOOST
  } state_t;

  typedef struct packed {
    logic [2:0]      func;
    logic [ID_W-1:0] proc_id;
  } in_word_t;

  typedef struct packed {
    logic            granted;
    logic [ID_W-1:0] granted_id;
    logic [1:0]      status;
  } out_word_t;

endpackage

// ----- hw/rtl/multilevel_feedback_queue_scheduler_unit.sv -----
// Multilevel feedback queue scheduler: NUM_LEVELS FIFO ready queues of process ids.
// Command channel: present in_word (func, proc_id) with start; the word is taken
// at a rising edge where start is high and busy is low. busy stays high until the
// command has finished.
// Result channel: every command returns exactly one out_word (granted, granted_id,
// status), shown for one cycle with out_valid high. The receiver cannot stall, so
// the word must be captured in that cycle.
// Admit, yield, wake, dispatch and unused codes: the accepting edge reads both
// memories (the per-process state, and the ready-queue slot at the head of the
// chosen queue), and the next edge writes back and registers the result. A new
// command may be accepted in the cycle the result is shown.
// Boost walks the per-process memory once, one process per cycle, through its
// single read and single write port.
// Reset clears the queue heads and counts, the result strobe, and the per-process
// valid bits; an entry that is not valid reads as level 0 and not queued. No
// clearing pass is run, so the first command may come right after reset.
module multilevel_feedback_queue_scheduler_unit #(
  parameter int NUM_LEVELS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mfqs_pkg::in_word_t  in_word,
  output logic                out_valid,
  output mfqs_pkg::out_word_t out_word
);

  localparam int ID_W      = mfqs_pkg::ID_W;
  localparam int NUM_PROCS = mfqs_pkg::NUM_PROCS;
  localparam int CNT_W     = mfqs_pkg::CNT_W;
  localparam int LVL_W     = $clog2(NUM_LEVELS);
  localparam int RS_DEPTH  = NUM_LEVELS * NUM_PROCS;
  localparam int RS_AW     = LVL_W + ID_W;
  localparam int PM_W      = LVL_W + 1;

  // control state
  mfqs_pkg::state_t    state_r, state_nxt;
  mfqs_pkg::func_t     cmd_r, cmd_nxt;
  logic [ID_W-1:0]     pid_r, pid_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic                found_r, found_nxt;
  logic [ID_W-1:0]     idx_r, idx_nxt;
  logic [ID_W-1:0]     head_r  [NUM_LEVELS];
  logic [ID_W-1:0]     head_nxt[NUM_LEVELS];
  logic [CNT_W-1:0]    count_r  [NUM_LEVELS];
  logic [CNT_W-1:0]    count_nxt[NUM_LEVELS];
  logic [NUM_PROCS-1:0] pm_valid_r, pm_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  mfqs_pkg::out_word_t out_word_r, out_word_nxt;

  // ready-queue bodies, addressed {level, slot}
  logic [ID_W-1:0]  rs_mem [RS_DEPTH];
  logic [ID_W-1:0]  rs_rdata_r;
  logic             rs_re;
  logic [RS_AW-1:0] rs_raddr;
  logic             rs_we;
  logic [RS_AW-1:0] rs_waddr;
  logic [ID_W-1:0]  rs_wdata;

  // per-process state: {queued, level}
  logic [PM_W-1:0]  pm_mem [NUM_PROCS];
  logic [PM_W-1:0]  pm_rdata_r;
  logic [ID_W-1:0]  pm_raddr_r;
  logic             pm_re;
  logic [ID_W-1:0]  pm_raddr;
  logic             pm_we;
  logic [ID_W-1:0]  pm_waddr;
  logic [PM_W-1:0]  pm_wdata;

  logic             accept;
  logic             found;
  logic [LVL_W-1:0] sel_lvl;
  logic [PM_W-1:0]  pm_ent;
  logic             ent_queued;
  logic [LVL_W-1:0] ent_lvl;
  logic [LVL_W-1:0] new_lvl;
  logic [ID_W-1:0]  push_slot;
  logic             cnt_ok;

  assign accept    = start && (state_r == mfqs_pkg::S_IDLE);
  assign busy      = (state_r != mfqs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // highest-priority non-empty queue
  always_comb begin
    found   = 1'b0;
    sel_lvl = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (count_r[l] != '0) begin
        found   = 1'b1;
        sel_lvl = LVL_W'(l);
      end
    end
  end

  assign pm_ent     = pm_valid_r[pm_raddr_r] ? pm_rdata_r : '0;
  assign ent_queued = pm_ent[LVL_W];
  assign ent_lvl    = pm_ent[LVL_W-1:0];

  always_comb begin
    unique case (cmd_r)
      mfqs_pkg::FN_ADMIT: new_lvl = '0;
      mfqs_pkg::FN_YIELD: new_lvl = (ent_lvl < LVL_W'(NUM_LEVELS - 1)) ?
                                    ent_lvl + LVL_W'(1) : ent_lvl;
      default:            new_lvl = ent_lvl;
    endcase
  end

  assign push_slot = head_r[new_lvl] + count_r[new_lvl][ID_W-1:0];

  assign rs_re    = accept;
  assign rs_raddr = {sel_lvl, head_r[sel_lvl]};
  assign pm_re    = accept || (state_r == mfqs_pkg::S_BOOST);

  always_comb begin
    if (state_r == mfqs_pkg::S_BOOST) begin
      pm_raddr = idx_r + ID_W'(1);
    end else if (mfqs_pkg::func_t'(in_word.func) == mfqs_pkg::FN_BOOST) begin
      pm_raddr = '0;
    end else begin
      pm_raddr = in_word.proc_id;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pid_nxt       = pid_r;
    lvl_nxt       = lvl_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pm_valid_nxt  = pm_valid_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = '0;
    rs_we         = 1'b0;
    rs_waddr      = '0;
    rs_wdata      = '0;
    pm_we         = 1'b0;
    pm_waddr      = '0;
    pm_wdata      = '0;

    unique case (state_r)
      mfqs_pkg::S_IDLE: begin
        if (accept) begin
          cmd_nxt   = mfqs_pkg::func_t'(in_word.func);
          pid_nxt   = in_word.proc_id;
          lvl_nxt   = sel_lvl;
          found_nxt = found;
          if (mfqs_pkg::func_t'(in_word.func) == mfqs_pkg::FN_BOOST) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
              head_nxt[l]  = '0;
              count_nxt[l] = '0;
            end
            idx_nxt   = '0;
            state_nxt = mfqs_pkg::S_BOOST;
          end else begin
            state_nxt = mfqs_pkg::S_EXEC;
          end
        end
      end

      mfqs_pkg::S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = mfqs_pkg::S_IDLE;
        unique case (cmd_r)
          mfqs_pkg::FN_ADMIT, mfqs_pkg::FN_YIELD, mfqs_pkg::FN_WAKE: begin
            if (ent_queued) begin
              out_word_nxt.status = mfqs_pkg::ST_DUP;
            end else begin
              rs_we                = 1'b1;
              rs_waddr             = {new_lvl, push_slot};
              rs_wdata             = pid_r;
              count_nxt[new_lvl]   = count_r[new_lvl] + CNT_W'(1);
              pm_we                = 1'b1;
              pm_waddr             = pid_r;
              pm_wdata             = {1'b1, new_lvl};
              pm_valid_nxt[pid_r]  = 1'b1;
            end
          end
          mfqs_pkg::FN_DISPATCH: begin
            if (found_r) begin
              // a queued process always sits in the queue of its own level
              head_nxt[lvl_r]            = head_r[lvl_r] + ID_W'(1);
              count_nxt[lvl_r]           = count_r[lvl_r] - CNT_W'(1);
              pm_we                      = 1'b1;
              pm_waddr                   = rs_rdata_r;
              pm_wdata                   = {1'b0, lvl_r};
              pm_valid_nxt[rs_rdata_r]   = 1'b1;
              out_word_nxt.granted       = 1'b1;
              out_word_nxt.granted_id    = rs_rdata_r;
            end else begin
              out_word_nxt.status = mfqs_pkg::ST_EMPTY;
            end
          end
          default: begin
          end
        endcase
      end

      mfqs_pkg::S_BOOST: begin
        // rebuild queue 0 in index order, keep queued flags, drop levels to 0
        if (ent_queued) begin
          rs_we        = 1'b1;
          rs_waddr     = {LVL_W'(0), count_r[0][ID_W-1:0]};
          rs_wdata     = idx_r;
          count_nxt[0] = count_r[0] + CNT_W'(1);
        end
        pm_we               = 1'b1;
        pm_waddr            = idx_r;
        pm_wdata            = {ent_queued, LVL_W'(0)};
        pm_valid_nxt[idx_r] = 1'b1;
        idx_nxt             = idx_r + ID_W'(1);
        if (idx_r == ID_W'(NUM_PROCS - 1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = mfqs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mfqs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfqs_pkg::S_IDLE;
      found_r     <= 1'b0;
      pm_valid_r  <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      pm_valid_r  <= pm_valid_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pid_r      <= pid_nxt;
    lvl_r      <= lvl_nxt;
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    if (rs_re) begin
      rs_rdata_r <= rs_mem[rs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pm_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pm_rdata_r <= pm_mem[pm_raddr];
      pm_raddr_r <= pm_raddr;
    end
  end

  always_comb begin
    cnt_ok = 1'b1;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (count_r[l] > CNT_W'(NUM_PROCS)) begin
        cnt_ok = 1'b0;
      end
    end
  end

  a_cmd_takes_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted without entering execution");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a command in flight");

  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.granted) |-> (out_word.status == mfqs_pkg::ST_OK))
    else $error("granted word carries a non-ok status");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ok)
    else $error("queue occupancy above process count");

endmodule
